// File: src/ntx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntx_pkg
// Shared types, constants and codes of the neighbor table with expiry.
// ----------------------------------------------------------------------------
package ntx_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TIME_W      = 48;
  localparam int IP_W        = 32;
  localparam int MAC_W       = 48;
  localparam int ATTR_W      = 32;

  // Input modes
  localparam logic [1:0] MODE_UPDATE = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_TX_ERR = 2'd2;
  localparam logic [1:0] MODE_PURGE  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_CLOSED = 2'd0;
  localparam logic [1:0] KIND_ANSWER = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_FULL   = 2'd3;

  // -1.0 in Q16.16
  localparam logic signed [ATTR_W-1:0] ATTR_ABSENT = 32'shFFFF_0000;

  typedef struct packed {
    logic [1:0]               mode;
    logic [IP_W-1:0]          ip_address;
    logic [MAC_W-1:0]         mac_address;
    logic [TIME_W-1:0]        now;
    logic [31:0]              hold_time;
    logic signed [ATTR_W-1:0] queue_ratio;
    logic signed [ATTR_W-1:0] heading;
    logic signed [ATTR_W-1:0] velocity;
    logic signed [ATTR_W-1:0] energy_ratio;
  } ntx_in_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [IP_W-1:0]          closed_address;
    logic                     found;
    logic [TIME_W-1:0]        remaining_time;
    logic signed [ATTR_W-1:0] out_queue_ratio;
    logic signed [ATTR_W-1:0] out_heading;
    logic signed [ATTR_W-1:0] out_velocity;
    logic signed [ATTR_W-1:0] out_energy_ratio;
    logic                     last;
  } ntx_out_t;

  // One table slot as held in the entry RAM
  typedef struct packed {
    logic [IP_W-1:0]          ip;
    logic [MAC_W-1:0]         mac;
    logic [TIME_W-1:0]        expiry;
    logic signed [ATTR_W-1:0] queue_ratio;
    logic signed [ATTR_W-1:0] heading;
    logic signed [ATTR_W-1:0] velocity;
    logic signed [ATTR_W-1:0] energy_ratio;
  } ntx_entry_t;

  localparam int ENTRY_W = $bits(ntx_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_EV,
    ST_UPDATE,
    ST_PURGE_RD,
    ST_PURGE_EV,
    ST_FINAL
  } ntx_state_e;

  typedef struct packed {
    logic capture;
    logic idx_clr;
    logic idx_inc;
    logic eval_find;
    logic eval_hit;
    logic upd_commit;
    logic wr_insert;
    logic wr_refresh;
    logic emit_notice;
    logic emit_final;
  } ntx_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       idx_last;
    logic       remove;
    logic       hit_found;
    logic       free_found;
    logic       out_free;
  } ntx_status_t;

endpackage

// File: src/ntx_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ntx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/ntx_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntx_ctrl
// Sequencer: slot scans for lookup and purge, write-back, result emission.
// ----------------------------------------------------------------------------
module ntx_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ntx_pkg::ntx_status_t sts_i,
  output ntx_pkg::ntx_cmd_t    cmd_o
);
  import ntx_pkg::*;

  ntx_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // advance past the slot under evaluation in a purge scan
  logic purge_step;
  assign purge_step = !sts_i.remove || sts_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (sts_i.mode == MODE_UPDATE) ? ST_FIND_RD : ST_PURGE_RD;
        end
      end
      ST_FIND_RD:  state_d = ST_FIND_EV;
      ST_FIND_EV:  state_d = sts_i.idx_last ? ST_UPDATE : ST_FIND_RD;
      ST_UPDATE:   state_d = sts_i.hit_found ? ST_FINAL : ST_PURGE_RD;
      ST_PURGE_RD: state_d = ST_PURGE_EV;
      ST_PURGE_EV: begin
        if (purge_step) begin
          state_d = sts_i.idx_last ? ST_FINAL : ST_PURGE_RD;
        end
      end
      ST_FINAL: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_FIND_RD: ;
      ST_FIND_EV: begin
        cmd_o.eval_find = 1'b1;
        cmd_o.idx_inc   = !sts_i.idx_last;
      end
      ST_UPDATE: begin
        cmd_o.upd_commit = 1'b1;
        cmd_o.wr_refresh = sts_i.hit_found;
        cmd_o.wr_insert  = !sts_i.hit_found && sts_i.free_found;
        cmd_o.idx_clr    = 1'b1;
      end
      ST_PURGE_RD: ;
      ST_PURGE_EV: begin
        cmd_o.eval_hit    = !sts_i.remove;
        cmd_o.emit_notice = sts_i.remove && sts_i.out_free;
        cmd_o.idx_inc     = purge_step && !sts_i.idx_last;
      end
      ST_FINAL: cmd_o.emit_final = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// File: src/ntx_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntx_dp
// Datapath: item register, valid bits, entry RAM, slot compare, output word.
// ----------------------------------------------------------------------------
module ntx_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ntx_pkg::ntx_in_t     in_word_i,
  input  ntx_pkg::ntx_cmd_t    cmd_i,
  output ntx_pkg::ntx_status_t sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ntx_pkg::ntx_out_t    out_word_o
);
  import ntx_pkg::*;

  ntx_in_t           item_q;
  logic [TIME_W-1:0] sum_q;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic              hit_found_q, free_found_q, drop_q;
  logic [IDX_W-1:0]  hit_idx_q, free_idx_q;
  ntx_entry_t        hit_q;
  logic              out_valid_q;
  ntx_out_t          out_q;

  ntx_entry_t        rd_entry, wr_entry;
  logic [ENTRY_W-1:0] rdata;
  logic              out_free, slot_valid, ip_match, remove;
  logic [TIME_W:0]   sum_wide;

  assign rd_entry   = ntx_entry_t'(rdata);
  assign slot_valid = valid_q[idx_q];
  assign ip_match   = slot_valid && (rd_entry.ip == item_q.ip_address);
  assign remove     = slot_valid && ((rd_entry.expiry < item_q.now) ||
                      ((item_q.mode == MODE_TX_ERR) &&
                       (rd_entry.mac == item_q.mac_address)));
  assign out_free   = !out_valid_q || !out_stall_i;

  // saturating now + hold
  assign sum_wide = {1'b0, item_q.now} + {{(TIME_W + 1 - 32){1'b0}}, item_q.hold_time};

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.capture || cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_comb begin
    wr_entry.ip           = item_q.ip_address;
    wr_entry.queue_ratio  = item_q.queue_ratio;
    wr_entry.heading      = item_q.heading;
    wr_entry.velocity     = item_q.velocity;
    wr_entry.energy_ratio = item_q.energy_ratio;
    if (cmd_i.wr_refresh) begin
      wr_entry.mac    = (hit_q.mac == '0) ? item_q.mac_address : hit_q.mac;
      wr_entry.expiry = (sum_q > hit_q.expiry) ? sum_q : hit_q.expiry;
    end else begin
      wr_entry.mac    = item_q.mac_address;
      wr_entry.expiry = sum_q;
    end
  end

  ntx_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_insert || cmd_i.wr_refresh),
    .waddr_i (cmd_i.wr_refresh ? hit_idx_q : free_idx_q),
    .wdata_i (wr_entry),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_word_i;
    end
    sum_q <= sum_wide[TIME_W] ? {TIME_W{1'b1}} : sum_wide[TIME_W-1:0];
    if ((cmd_i.eval_find || (cmd_i.eval_hit && item_q.mode == MODE_QUERY)) &&
        ip_match && !hit_found_q) begin
      hit_idx_q <= idx_q;
      hit_q     <= rd_entry;
    end
    if (cmd_i.eval_find && !slot_valid && !free_found_q) begin
      free_idx_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      valid_q      <= '0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      drop_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.capture) begin
        hit_found_q  <= 1'b0;
        free_found_q <= 1'b0;
        drop_q       <= 1'b0;
      end else begin
        if ((cmd_i.eval_find || (cmd_i.eval_hit && item_q.mode == MODE_QUERY)) &&
            ip_match) begin
          hit_found_q <= 1'b1;
        end
        if (cmd_i.eval_find && !slot_valid) begin
          free_found_q <= 1'b1;
        end
        if (cmd_i.upd_commit) begin
          drop_q <= !hit_found_q && !free_found_q;
        end
      end
      if (cmd_i.wr_insert) begin
        valid_q[free_idx_q] <= 1'b1;
      end
      if (cmd_i.emit_notice) begin
        valid_q[idx_q] <= 1'b0;
      end
      if (cmd_i.emit_notice || cmd_i.emit_final) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_notice) begin
      out_q                <= '0;
      out_q.kind           <= KIND_CLOSED;
      out_q.closed_address <= rd_entry.ip;
    end else if (cmd_i.emit_final) begin
      out_q      <= '0;
      out_q.last <= 1'b1;
      if (item_q.mode == MODE_QUERY) begin
        out_q.kind <= KIND_ANSWER;
        if (hit_found_q) begin
          out_q.found            <= 1'b1;
          out_q.remaining_time   <= hit_q.expiry - item_q.now;
          out_q.out_queue_ratio  <= hit_q.queue_ratio;
          out_q.out_heading      <= hit_q.heading;
          out_q.out_velocity     <= hit_q.velocity;
          out_q.out_energy_ratio <= hit_q.energy_ratio;
        end else begin
          out_q.out_queue_ratio  <= ATTR_ABSENT;
          out_q.out_heading      <= ATTR_ABSENT;
          out_q.out_velocity     <= ATTR_ABSENT;
          out_q.out_energy_ratio <= ATTR_ABSENT;
        end
      end else begin
        out_q.kind <= drop_q ? KIND_FULL : KIND_DONE;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign sts_o.mode       = cmd_i.capture ? in_word_i.mode : item_q.mode;
  assign sts_o.idx_last   = (idx_q == IDX_W'(TABLE_DEPTH - 1));
  assign sts_o.remove     = remove;
  assign sts_o.hit_found  = hit_found_q;
  assign sts_o.free_found = free_found_q;
  assign sts_o.out_free   = out_free;

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_notice || cmd_i.emit_final) |-> out_free)
    else $error("result emitted while output word held");

  a_insert_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_insert |=> valid_q[$past(free_idx_q)])
    else $error("inserted slot not marked valid");

  a_notice_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_notice |=> !valid_q[$past(idx_q)])
    else $error("purged slot still valid");

endmodule

// File: src/neighbor_table_with_expiry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_table_with_expiry
// Neighbor table keyed by IPv4 address with expiry, close-by-MAC and purge.
// ----------------------------------------------------------------------------
// The table holds TABLE_DEPTH slots in one entry RAM (IP, MAC, expiry, four
// Q16.16 attributes) plus a valid flop per slot. Every item is handled one at
// a time by slot scans, each slot taking a RAM read state and then an evaluate
// state, so the single RAM read port sets the rate. From one accepting edge to
// the next: an update hit runs accept, one scan for a match and a free slot,
// write-back and final word, and is answered without a purge; query, tx error
// and timed purge run accept, one purge scan and final word; an update miss
// inserts into a free slot, if one was found, and then purges, running both
// scans. Each removed slot gives a closed notice word in slot order, and every
// item ends with one final word carrying last = 1; a stalled output holds the
// purge scan and the final word. A transmit error removes matching MACs in the
// same pass as the expiry purge. No clearing pass after reset.
// ----------------------------------------------------------------------------
module neighbor_table_with_expiry (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ntx_pkg::ntx_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ntx_pkg::ntx_out_t out_word_o
);
  import ntx_pkg::*;

  ntx_cmd_t    cmd;
  ntx_status_t sts;

  // sequencer
  ntx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table, compare and output word
  ntx_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
